### design/led_strip_frame_generator_top_assert.svh
// Assertion macros for the LED strip frame generator checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef LED_STRIP_FRAME_GENERATOR_TOP_ASSERT_SVH
`define LED_STRIP_FRAME_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LSFG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsfg: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define LSFG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsfg: next-cycle check failed");

`endif

### design/lsfg_pkg.sv
// Shared types, sizes, constant tables and helper functions for the
// LED strip frame generator. No dependencies.
package lsfg_pkg;

  localparam int LED_COUNT    = 16;
  localparam int RESET_SLOTS  = 2;
  localparam int WAVE_LENGTH  = 32;
  localparam int PULSE_PERIOD = 8;

  localparam int TOTAL_SLOTS = 2 * RESET_SLOTS + LED_COUNT;
  localparam int SLOT_W      = 6;
  localparam int LEVEL_W     = 8;
  localparam int SYM_W       = 4;
  localparam int CODE_W      = 32;
  localparam int BRIGHT_W    = 9;
  localparam int HS_W        = 24;
  localparam int PROD_W      = BRIGHT_W + HS_W;
  localparam int WAVE_W      = $clog2(WAVE_LENGTH);
  localparam int PULSE_W     = (PULSE_PERIOD > 1) ? $clog2(PULSE_PERIOD) : 1;
  localparam int OFF_G       = WAVE_LENGTH / 3;
  localparam int OFF_B       = WAVE_LENGTH * 2 / 3;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TOTAL_SLOTS - 1);
  localparam logic [SLOT_W:0]   FIRST_LED = (SLOT_W + 1)'(RESET_SLOTS);
  localparam logic [SLOT_W:0]   END_LED   = (SLOT_W + 1)'(RESET_SLOTS + LED_COUNT);

  localparam logic [SYM_W-1:0]    ONE_SYM_RST  = 4'd14;
  localparam logic [SYM_W-1:0]    ZERO_SYM_RST = 4'd8;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST   = 9'd256;

  typedef enum logic [1:0] {
    CMD_PURE  = 2'd0,
    CMD_WAVE  = 2'd1,
    CMD_PULSE = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    REG_ONE_SYM  = 2'd0,
    REG_ZERO_SYM = 2'd1,
    REG_BRIGHT   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [LEVEL_W-1:0] phase;
    logic [LEVEL_W-1:0] pulse_length;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] red_code;
    logic [CODE_W-1:0] green_code;
    logic [CODE_W-1:0] blue_code;
    logic [SLOT_W-1:0] slot_number;
    logic              reset_slot;
    logic              last;
  } slot_t;

  typedef struct packed {
    logic [SYM_W-1:0]    one_symbol;
    logic [SYM_W-1:0]    zero_symbol;
    logic [BRIGHT_W-1:0] brightness;
  } cfg_t;

  // Per-slot context handed from the frame sequencer to the encoder.
  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  slot_number;
    logic               reset_slot;
    logic               last;
    logic [1:0]         command;
    logic               lit;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [WAVE_W-1:0]  k_red;
    logic [WAVE_W-1:0]  k_green;
    logic [WAVE_W-1:0]  k_blue;
  } ctx_t;

  typedef logic [7:0]      mod_tab_t [256];
  typedef logic [HS_W-1:0] hs_tab_t [WAVE_LENGTH];

  // Byte value modulo m, built by counting so no divider is involved.
  function automatic mod_tab_t build_mod_tab(int unsigned m);
    mod_tab_t    t;
    int unsigned c;
    c = 0;
    for (int p = 0; p < 256; p++) begin
      t[p] = 8'(c);
      c = (c == m - 1) ? 0 : c + 1;
    end
    return t;
  endfunction

  function automatic longint quarter_cos(longint u);
    longint u2, a, b, c, r;
    u2 = (u * u) >>> 16;
    a  = 1367 - ((u2 * 60) >>> 16);
    b  = 16624 - ((u2 * a) >>> 16);
    c  = 80852 - ((u2 * b) >>> 16);
    r  = 65536 - ((u2 * c) >>> 16);
    if (r < 0) r = 0;
    if (r > 65536) r = 65536;
    return r;
  endfunction

  // 255 * (1 + cos) / 2 in Q16, one entry per wave position.
  function automatic hs_tab_t build_hs_tab();
    hs_tab_t t;
    longint  n, q, rem, tf, cs, h;
    for (int k = 0; k < WAVE_LENGTH; k++) begin
      n   = 4 * k;
      q   = n / WAVE_LENGTH;
      rem = n - q * WAVE_LENGTH;
      tf  = (rem << 16) / WAVE_LENGTH;
      case (q)
        0:       cs = quarter_cos(tf);
        1:       cs = -quarter_cos(65536 - tf);
        2:       cs = -quarter_cos(tf);
        default: cs = quarter_cos(65536 - tf);
      endcase
      h    = (65536 + cs) / 2;
      t[k] = HS_W'(255 * h);
    end
    return t;
  endfunction

  localparam mod_tab_t WAVE_MOD_TAB  = build_mod_tab(WAVE_LENGTH);
  localparam mod_tab_t PULSE_MOD_TAB = build_mod_tab(PULSE_PERIOD);
  localparam hs_tab_t  HS_TAB        = build_hs_tab();

  // Scale a table entry by brightness and saturate to one byte.
  function automatic logic [LEVEL_W-1:0] wave_level(logic [BRIGHT_W-1:0] bright,
                                                    logic [HS_W-1:0] hs);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(bright) * PROD_W'(hs);
    if (|prod[PROD_W-1:HS_W+LEVEL_W]) return '1;
    return prod[HS_W+LEVEL_W-1:HS_W];
  endfunction

  // One symbol per bit, MSB symbol in the top nibble.
  function automatic logic [CODE_W-1:0] encode_level(logic [LEVEL_W-1:0] level,
                                                     logic [SYM_W-1:0] one_s,
                                                     logic [SYM_W-1:0] zero_s);
    logic [CODE_W-1:0] code;
    for (int k = 0; k < LEVEL_W; k++) begin
      code[SYM_W*k +: SYM_W] = level[k] ? one_s : zero_s;
    end
    return code;
  endfunction

endpackage

### design/lsfg_cmd_if.sv
// Frame command channel: valid/ready handshake with a cmd_t payload.
// Depends on lsfg_pkg.
interface lsfg_cmd_if;
  import lsfg_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/lsfg_slot_if.sv
// Slot result channel: valid/ready handshake with a slot_t payload.
// Depends on lsfg_pkg.
interface lsfg_slot_if;
  import lsfg_pkg::*;

  logic  valid;
  logic  ready;
  slot_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/led_strip_frame_generator_top.sv
// LED strip frame generator top level: configuration registers, frame
// sequencer, slot encoder and result register. Depends on lsfg_pkg.
//
// Usage:
//   in_cmd   takes one frame command (mode, phase, pulse length, colour).
//   out_slot gives one item per frame slot: reset slots first, then one
//            slot per LED, then the trailing reset slots; the final slot of
//            a frame carries last. TOTAL_SLOTS items per command (20 at the
//            default sizes).
//   APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the one
//            and zero SPI symbols and the wave brightness; write it only
//            while no frame is in flight.
// Timing: an accepted command is held in the sequencer's command register,
//   each slot passes through the result register, and slots follow one per
//   cycle while the receiver takes them. The next command is accepted at the
//   edge where the last slot of the current frame enters the result register,
//   so frames run back to back with no gap.
// Reset: rst_n (synchronous, active low) drops any frame in flight, empties
//   the result register and restores the register defaults.
// Stall: while out_slot is held not ready, the result register holds its
//   item and the sequencer holds its slot; in_cmd ready stays low mid-frame.
module led_strip_frame_generator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  lsfg_cmd_if.sink                    in_cmd,
  lsfg_slot_if.source                 out_slot,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsfg_pkg::CFG_AW-1:0] paddr,
  input  logic [lsfg_pkg::CFG_DW-1:0] pwdata,
  output logic [lsfg_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import lsfg_pkg::*;

  cfg_t  cfg;
  ctx_t  ctx;
  slot_t slot;
  logic  advance;

  // Register file: symbols and brightness, read back on prdata.
  lsfg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold the command, count slots, advance the wave and pulse indices.
  lsfg_frame_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (in_cmd),
    .advance (advance),
    .ctx     (ctx)
  );

  // Turn the current slot into SPI symbol words.
  lsfg_slot_enc u_enc (
    .ctx  (ctx),
    .cfg  (cfg),
    .slot (slot)
  );

  // Register the result; step the sequencer whenever this stage can load.
  lsfg_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_valid (ctx.valid),
    .slot_d     (slot),
    .advance    (advance),
    .out_slot   (out_slot)
  );
endmodule

### design/lsfg_cfg_regs.sv
// APB-style configuration registers: symbols and wave brightness.
// Depends on lsfg_pkg.
module lsfg_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsfg_pkg::CFG_AW-1:0] paddr,
  input  logic [lsfg_pkg::CFG_DW-1:0] pwdata,
  output logic [lsfg_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output lsfg_pkg::cfg_t            cfg
);
  import lsfg_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ONE_SYM:  cfg_nxt.one_symbol  = pwdata[SYM_W-1:0];
        REG_ZERO_SYM: cfg_nxt.zero_symbol = pwdata[SYM_W-1:0];
        REG_BRIGHT:   cfg_nxt.brightness  = pwdata[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ONE_SYM:  prdata = CFG_DW'(cfg_r.one_symbol);
      REG_ZERO_SYM: prdata = CFG_DW'(cfg_r.zero_symbol);
      REG_BRIGHT:   prdata = CFG_DW'(cfg_r.brightness);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_symbol  <= ONE_SYM_RST;
      cfg_r.zero_symbol <= ZERO_SYM_RST;
      cfg_r.brightness  <= BRIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

### design/lsfg_frame_ctrl.sv
// Frame sequencer: command register, slot counter and running wave and
// pulse indices. Depends on lsfg_pkg and lsfg_cmd_if.
module lsfg_frame_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  lsfg_cmd_if.sink       in_cmd,
  input  logic           advance,
  output lsfg_pkg::ctx_t ctx
);
  import lsfg_pkg::*;

  logic               active_r, active_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [WAVE_W-1:0]  kr_r, kr_nxt, kg_r, kg_nxt, kb_r, kb_nxt;
  logic [PULSE_W-1:0] pidx_r, pidx_nxt;

  logic              at_last, led_slot, step, accept;
  logic [WAVE_W-1:0] k0;

  function automatic logic [WAVE_W-1:0] wave_wrap(logic [WAVE_W-1:0] a,
                                                  logic [WAVE_W:0] off);
    logic [WAVE_W:0] s;
    s = {1'b0, a} + off;
    if (s >= (WAVE_W + 1)'(WAVE_LENGTH)) s = s - (WAVE_W + 1)'(WAVE_LENGTH);
    return s[WAVE_W-1:0];
  endfunction

  function automatic logic [WAVE_W-1:0] wave_inc(logic [WAVE_W-1:0] a);
    return (a == WAVE_W'(WAVE_LENGTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_inc(logic [PULSE_W-1:0] a);
    return (a == PULSE_W'(PULSE_PERIOD - 1)) ? '0 : a + 1'b1;
  endfunction

  assign at_last  = (slot_r == LAST_SLOT);
  assign led_slot = ({1'b0, slot_r} >= FIRST_LED) && ({1'b0, slot_r} < END_LED);
  assign step     = active_r && advance;
  // Hold ready low while reset is applied so no command is taken and dropped.
  assign in_cmd.ready = rst_n && (!active_r || (advance && at_last));
  assign accept   = in_cmd.valid && in_cmd.ready;
  assign k0       = WAVE_MOD_TAB[in_cmd.data.phase][WAVE_W-1:0];

  always_comb begin
    active_nxt = active_r;
    slot_nxt   = slot_r;
    cmd_nxt    = cmd_r;
    kr_nxt     = kr_r;
    kg_nxt     = kg_r;
    kb_nxt     = kb_r;
    pidx_nxt   = pidx_r;
    if (accept) begin
      active_nxt = 1'b1;
      slot_nxt   = '0;
      cmd_nxt    = in_cmd.data;
      kr_nxt     = k0;
      kg_nxt     = wave_wrap(k0, (WAVE_W + 1)'(OFF_G));
      kb_nxt     = wave_wrap(k0, (WAVE_W + 1)'(OFF_B));
      pidx_nxt   = PULSE_MOD_TAB[in_cmd.data.phase][PULSE_W-1:0];
    end else if (step) begin
      if (at_last) active_nxt = 1'b0;
      slot_nxt = slot_r + 1'b1;
      if (led_slot) begin
        kr_nxt   = wave_inc(kr_r);
        kg_nxt   = wave_inc(kg_r);
        kb_nxt   = wave_inc(kb_r);
        pidx_nxt = pulse_inc(pidx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      slot_r   <= '0;
    end else begin
      active_r <= active_nxt;
      slot_r   <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    kr_r   <= kr_nxt;
    kg_r   <= kg_nxt;
    kb_r   <= kb_nxt;
    pidx_r <= pidx_nxt;
  end

  always_comb begin
    ctx.valid       = active_r;
    ctx.slot_number = slot_r;
    ctx.reset_slot  = !led_slot;
    ctx.last        = at_last;
    ctx.command     = cmd_r.command;
    ctx.lit         = (8'(pidx_r) < cmd_r.pulse_length);
    ctx.red         = cmd_r.red;
    ctx.green       = cmd_r.green;
    ctx.blue        = cmd_r.blue;
    ctx.k_red       = kr_r;
    ctx.k_green     = kg_r;
    ctx.k_blue      = kb_r;
  end
endmodule

### design/lsfg_slot_enc.sv
// Slot encoder: picks the colour for the slot's mode and turns each
// channel into SPI symbol words. Depends on lsfg_pkg.
module lsfg_slot_enc (
  input  lsfg_pkg::ctx_t  ctx,
  input  lsfg_pkg::cfg_t  cfg,
  output lsfg_pkg::slot_t slot
);
  import lsfg_pkg::*;

  logic [LEVEL_W-1:0] wr, wg, wb;
  logic [LEVEL_W-1:0] r, g, b;

  assign wr = wave_level(cfg.brightness, HS_TAB[ctx.k_red]);
  assign wg = wave_level(cfg.brightness, HS_TAB[ctx.k_green]);
  assign wb = wave_level(cfg.brightness, HS_TAB[ctx.k_blue]);

  always_comb begin
    case (cmd_code_t'(ctx.command))
      CMD_PURE: begin
        r = ctx.red;
        g = ctx.green;
        b = ctx.blue;
      end
      CMD_WAVE: begin
        r = wr;
        g = wg;
        b = wb;
      end
      CMD_PULSE: begin
        r = ctx.lit ? ctx.red   : '0;
        g = ctx.lit ? ctx.green : '0;
        b = ctx.lit ? ctx.blue  : '0;
      end
      default: begin
        r = '0;
        g = '0;
        b = '0;
      end
    endcase
  end

  always_comb begin
    slot.slot_number = ctx.slot_number;
    slot.reset_slot  = ctx.reset_slot;
    slot.last        = ctx.last;
    if (ctx.reset_slot) begin
      slot.red_code   = '0;
      slot.green_code = '0;
      slot.blue_code  = '0;
    end else begin
      slot.red_code   = encode_level(r, cfg.one_symbol, cfg.zero_symbol);
      slot.green_code = encode_level(g, cfg.one_symbol, cfg.zero_symbol);
      slot.blue_code  = encode_level(b, cfg.one_symbol, cfg.zero_symbol);
    end
  end
endmodule

### design/lsfg_out_reg.sv
// Result register on the slot channel; tells the sequencer when it may step.
// Depends on lsfg_pkg and lsfg_slot_if.
module lsfg_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            slot_valid,
  input  lsfg_pkg::slot_t slot_d,
  output logic            advance,
  lsfg_slot_if.source     out_slot
);
  import lsfg_pkg::*;

  logic  valid_r, valid_nxt;
  slot_t data_r;

  assign advance   = !valid_r || out_slot.ready;
  assign valid_nxt = advance ? slot_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && slot_valid) begin
      data_r <= slot_d;
    end
  end

  assign out_slot.valid = valid_r;
  assign out_slot.data  = data_r;
endmodule

### design/lsfg_checker.sv
// Port-level checks on the slot channel of the frame generator, bound to
// the top level. Depends on lsfg_pkg and the assertion macro header.
`include "led_strip_frame_generator_top_assert.svh"

module lsfg_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input lsfg_pkg::slot_t out_data
);
  import lsfg_pkg::*;

  // Within a frame the next slot follows at once, numbered one higher.
  `LSFG_ASSERT_NXT(a_slot_seq, out_valid && out_ready && !out_data.last, out_valid && (out_data.slot_number == $past(out_data.slot_number) + 1'b1))

  // Reset slots carry no colour symbols.
  `LSFG_ASSERT_IMP(a_reset_zero, out_valid && out_data.reset_slot, (out_data.red_code == '0) && (out_data.green_code == '0) && (out_data.blue_code == '0))

  // The frame ends exactly at its final slot position.
  `LSFG_ASSERT_IMP(a_last_pos, out_valid, out_data.last == (out_data.slot_number == LAST_SLOT))

  // A stalled item holds.
  `LSFG_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind led_strip_frame_generator_top lsfg_checker u_lsfg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_slot.valid),
  .out_ready (out_slot.ready),
  .out_data  (out_slot.data)
);

### verif/led_strip_frame_generator_top_tb.sv
// Self-checking testbench for led_strip_frame_generator_top: frame commands in,
// per-slot SPI codes out, checked against an in-bench frame predictor.
// Depends on lsfg_pkg, lsfg_cmd_if and lsfg_slot_if.
module led_strip_frame_generator_top_tb;
  import lsfg_pkg::*;

  // Command code that the block leaves unused, and a register index past the list.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int MAX_IDLE      = 10;
  localparam int REPORT_LIMIT  = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_CHUNKS = 9;
  localparam int CHUNK_ITEMS   = 10;

  logic clk;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  lsfg_cmd_if  cmd_ch ();
  lsfg_slot_if slot_ch ();

  led_strip_frame_generator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (cmd_ch),
    .out_slot (slot_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor's copy of the configuration registers.
  logic [SYM_W-1:0]    one_sym_q;
  logic [SYM_W-1:0]    zero_sym_q;
  logic [BRIGHT_W-1:0] bright_q;

  // Slots predicted for accepted commands, oldest first.
  slot_t expected_slots [$];

  int  mismatch_count;
  int  cycle_count;
  bit  tx_idle_on;
  bit  rx_idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run: the slowest legal run stays far below this limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Quarter-wave cosine polynomial in Q16; argument is the Q16 fraction.
  function automatic longint cos_poly(longint u);
    longint sq, p;
    sq = (u * u) >>> 16;
    p  = 1367 - ((sq * 60) >>> 16);
    p  = 16624 - ((sq * p) >>> 16);
    p  = 80852 - ((sq * p) >>> 16);
    p  = 65536 - ((sq * p) >>> 16);
    if (p < 0) p = 0;
    if (p > 65536) p = 65536;
    return p;
  endfunction

  // Colour level at wave position k, scaled by brightness, saturating at 255.
  function automatic logic [LEVEL_W-1:0] cos_level(int unsigned k);
    longint n, q, rem, frac, cs, h, lv;
    n    = 4 * longint'(k);
    q    = n / WAVE_LENGTH;
    rem  = n - q * WAVE_LENGTH;
    frac = (rem <<< 16) / WAVE_LENGTH;
    case (q % 4)
      0:       cs = cos_poly(frac);
      1:       cs = -cos_poly(65536 - frac);
      2:       cs = -cos_poly(frac);
      default: cs = cos_poly(65536 - frac);
    endcase
    h  = (65536 + cs) / 2;
    lv = (255 * longint'(bright_q) * h) >>> 24;
    if (lv > 255) return 8'hFF;
    return lv[LEVEL_W-1:0];
  endfunction

  // Shift in one symbol per colour bit, MSB first.
  function automatic logic [CODE_W-1:0] spi_code(logic [LEVEL_W-1:0] level);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int b = LEVEL_W - 1; b >= 0; b--) begin
      code = {code[CODE_W-SYM_W-1:0], level[b] ? one_sym_q : zero_sym_q};
    end
    return code;
  endfunction

  // Queue every slot of the frame that one accepted command produces.
  task automatic predict_frame(cmd_t c);
    slot_t          s_exp;
    bit             is_rst;
    int unsigned    led, base;
    logic [LEVEL_W-1:0] r, g, b;
    for (int s = 0; s < TOTAL_SLOTS; s++) begin
      is_rst = (s < RESET_SLOTS) || (s >= RESET_SLOTS + LED_COUNT);
      s_exp  = '0;
      if (!is_rst) begin
        led = s - RESET_SLOTS;
        r = '0;
        g = '0;
        b = '0;
        case (c.command)
          CMD_PURE: begin
            r = c.red;
            g = c.green;
            b = c.blue;
          end
          CMD_WAVE: begin
            base = led + c.phase;
            r = cos_level(base % WAVE_LENGTH);
            g = cos_level((base + WAVE_LENGTH / 3) % WAVE_LENGTH);
            b = cos_level((base + WAVE_LENGTH * 2 / 3) % WAVE_LENGTH);
          end
          CMD_PULSE: begin
            // Light only the LEDs inside the pulse window of their period.
            if ((led + c.phase) % PULSE_PERIOD < c.pulse_length) begin
              r = c.red;
              g = c.green;
              b = c.blue;
            end
          end
          default: ;  // unused code: every LED goes dark
        endcase
        s_exp.red_code   = spi_code(r);
        s_exp.green_code = spi_code(g);
        s_exp.blue_code  = spi_code(b);
      end
      s_exp.slot_number = SLOT_W'(s);
      s_exp.reset_slot  = is_rst;
      s_exp.last        = (s == TOTAL_SLOTS - 1);
      expected_slots.push_back(s_exp);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: draws its own stall per item and checks each slot taken
  // ---------------------------------------------------------------------------

  task automatic check_field(logic [SLOT_W-1:0] slot, string field, logic [31:0] want,
                             logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("slot %0d %s: expected %h, got %h", slot, field, want, got);
    end
  endtask

  initial begin : slot_checker
    slot_t       got;
    slot_t       want;
    int unsigned stall;
    slot_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        slot_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      slot_ch.ready <= 1'b1;
      // Values read right after the edge are the ones the edge sampled.
      do @(posedge clk); while (slot_ch.valid !== 1'b1);
      got = slot_ch.data;
      if (expected_slots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected slot item: slot_number %0d", got.slot_number);
      end else begin
        want = expected_slots.pop_front();
        check_field(want.slot_number, "red_code", want.red_code, got.red_code);
        check_field(want.slot_number, "green_code", want.green_code, got.green_code);
        check_field(want.slot_number, "blue_code", want.blue_code, got.blue_code);
        check_field(want.slot_number, "slot_number", 32'(want.slot_number),
                    32'(got.slot_number));
        check_field(want.slot_number, "reset_slot", 32'(want.reset_slot),
                    32'(got.reset_slot));
        check_field(want.slot_number, "last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cmd_t make_cmd(logic [1:0] command, logic [7:0] phase,
                                    logic [7:0] plen, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b);
    cmd_t c;
    c.command      = command;
    c.phase        = phase;
    c.pulse_length = plen;
    c.red          = r;
    c.green        = g;
    c.blue         = b;
    return c;
  endfunction

  // Offer one command after a random gap; predict its frame once accepted.
  // Called at the edge of the previous handshake, so valid gets one update per step.
  task automatic send_frame(cmd_t c);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    predict_frame(c);
  endtask

  // Drop valid and hold until every predicted slot has come back.
  task automatic drain_frames();
    cmd_ch.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge that closes the access cycle. Only issued while idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain_frames();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ONE_SYM:  one_sym_q  = value[SYM_W-1:0];
      REG_ZERO_SYM: zero_sym_q = value[SYM_W-1:0];
      REG_BRIGHT:   bright_q   = value[BRIGHT_W-1:0];
      default: ;  // past the register list: no effect
    endcase
  endtask

  function automatic cmd_t random_cmd();
    int unsigned pick;
    cmd_t        c;
    pick = $urandom_range(0, 15);
    c = make_cmd(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
    if (pick < 5) c.command = CMD_PURE;
    else if (pick < 10) c.command = CMD_WAVE;
    else if (pick < 15) c.command = CMD_PULSE;
    else c.command = CMD_UNUSED;
    // Keep about half the pulse lengths near the period so the window edge moves.
    if ($urandom_range(0, 1) == 0) c.pulse_length = 8'($urandom_range(0, PULSE_PERIOD + 1));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the symbols: pure colour at both level extremes and a mixed pattern.
  task automatic test_pure_extremes();
    send_frame(make_cmd(CMD_PURE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(make_cmd(CMD_PURE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(make_cmd(CMD_PURE, 8'h5A, 8'hA5, 8'hAA, 8'h55, 8'h0F));
  endtask

  // Symbol registers at their extremes, then back to the usual codes.
  task automatic test_symbol_extremes();
    write_reg(REG_ONE_SYM, 32'h0);
    write_reg(REG_ZERO_SYM, 32'hF);
    send_frame(make_cmd(CMD_PURE, 8'h00, 8'h00, 8'hF0, 8'h0F, 8'h81));
    write_reg(REG_ONE_SYM, 32'hFFFF_FFFF);
    write_reg(REG_ZERO_SYM, 32'hFFFF_FFF0);
    send_frame(make_cmd(CMD_PURE, 8'h00, 8'h00, 8'h3C, 8'hC3, 8'h7E));
    write_reg(REG_ONE_SYM, 32'(ONE_SYM_RST));
    write_reg(REG_ZERO_SYM, 32'(ZERO_SYM_RST));
  endtask

  // Cosine wave at full brightness across the phase range.
  task automatic test_wave_phases();
    send_frame(make_cmd(CMD_WAVE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_frame(make_cmd(CMD_WAVE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(make_cmd(CMD_WAVE, 8'(WAVE_LENGTH / 3), 8'h12, 8'h34, 8'h56, 8'h78));
  endtask

  // Brightness from zero through full to above full, where levels saturate.
  task automatic test_brightness();
    write_reg(REG_BRIGHT, 32'd0);
    send_frame(make_cmd(CMD_WAVE, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00));
    write_reg(REG_BRIGHT, 32'd1);
    send_frame(make_cmd(CMD_WAVE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    write_reg(REG_BRIGHT, 32'd257);
    send_frame(make_cmd(CMD_WAVE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    write_reg(REG_BRIGHT, 32'hFFFF_FFFF);
    send_frame(make_cmd(CMD_WAVE, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00));
    write_reg(REG_BRIGHT, 32'(BRIGHT_RST));
  endtask

  // Pulse window empty, one LED, just under the period, the period, and maximum.
  task automatic test_pulse_lengths();
    send_frame(make_cmd(CMD_PULSE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_frame(make_cmd(CMD_PULSE, 8'hFF, 8'h01, 8'hC0, 8'h3F, 8'h99));
    send_frame(make_cmd(CMD_PULSE, 8'h03, 8'(PULSE_PERIOD - 1), 8'h11, 8'h22, 8'h44));
    send_frame(make_cmd(CMD_PULSE, 8'h05, 8'(PULSE_PERIOD), 8'hFF, 8'h00, 8'h80));
    send_frame(make_cmd(CMD_PULSE, 8'hA7, 8'hFF, 8'h01, 8'hFE, 8'h7F));
  endtask

  // Unused command code: LEDs dark whatever the colour fields say.
  task automatic test_unused_command();
    send_frame(make_cmd(CMD_UNUSED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(make_cmd(CMD_UNUSED, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF));
  endtask

  // A write past the register list must leave every register as it was.
  task automatic test_unused_register();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_frame(make_cmd(CMD_PURE, 8'h00, 8'h00, 8'hC9, 8'h36, 8'hE1));
    send_frame(make_cmd(CMD_WAVE, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // Random commands in chunks; each chunk gets fresh registers and idle mode.
  task automatic test_random_frames();
    int unsigned pick;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      write_reg(REG_ONE_SYM, $urandom);
      write_reg(REG_ZERO_SYM, $urandom);
      pick = $urandom_range(0, 3);
      case (pick)
        0:       write_reg(REG_BRIGHT, 32'd0);
        1:       write_reg(REG_BRIGHT, 32'(BRIGHT_RST));
        2:       write_reg(REG_BRIGHT, 32'h1FF);
        default: write_reg(REG_BRIGHT, $urandom);
      endcase
      // First chunk runs with no idling on either side.
      tx_idle_on = (chunk != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (chunk != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < CHUNK_ITEMS; n++) send_frame(random_cmd());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    one_sym_q      = ONE_SYM_RST;
    zero_sym_q     = ZERO_SYM_RST;
    bright_q       = BRIGHT_RST;

    // Drive every input to a known value and hold reset.
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pure_extremes();
    test_symbol_extremes();
    test_wave_phases();
    test_brightness();
    test_pulse_lengths();
    test_unused_command();
    test_unused_register();
    test_random_frames();

    // Wait out the outstanding slots, then keep watching for strays.
    cmd_ch.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (TOTAL_SLOTS + 10) @(posedge clk);

    if (mismatch_count == 0 && expected_slots.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
